[src/assert_macros.svh]
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define AST_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// condition that must never hold outside reset
`define AST_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");

`endif

[src/bpcs_pkg.sv]
package bpcs_pkg;

  typedef enum logic [1:0] {
    KIND_READ    = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_DIRTY   = 2'd2,
    KIND_NONE    = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_HIT       = 3'd0,
    ST_MISS      = 3'd1,
    ST_WRITEBACK = 3'd2,
    ST_RELEASED  = 3'd3,
    ST_NO_VICTIM = 3'd4,
    ST_BAD_REL   = 3'd5
  } status_e;

  localparam logic [7:0] PIN_MAX = 8'hFF;

  typedef struct packed {
    logic [31:0] blk;
    logic [15:0] fil;
    logic [7:0]  pin;
    logic [3:0]  usage;
    logic        dirty;
  } entry_t;

endpackage

[src/buffer_pool_clock_sweep.sv]
// release and mark dirty read the named slot once; a read scans the tags from slot 0 up to a hit
// a miss scans every tag, then sweeps the slots from the clock hand until it finds a victim or none
// one item at a time: tag scan and sweep read one slot at a time from the slot ram and then check it
// a result may wait in the output register while the next item is taken
// a result that meets a stalled, full output register holds the block until it is free
// reset (async, active low) empties all slots, zeroes the hand, sets usage_limit to 5
module buffer_pool_clock_sweep
  import bpcs_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [31:0] block_number_i,
  input  logic [15:0] file_number_i,
  input  logic [3:0]  slot_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [3:0]  out_slot_o,
  output logic [31:0] out_block_o,
  output logic [15:0] out_file_o,
  output logic        last_o,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_data_i
);

  localparam int SW = $clog2(SLOTS);

  logic [3:0]    usage_limit_q;
  logic          ram_we;
  logic [SW-1:0] ram_waddr, ram_raddr;
  entry_t        ram_wdata, ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      usage_limit_q <= 4'd5;
    end else if (cfg_we_i) begin
      usage_limit_q <= cfg_data_i;
    end
  end

  bpcs_ram #(
    .Width($bits(entry_t)),
    .Depth(SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bpcs_ctrl #(
    .SLOTS(SLOTS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .block_number_i (block_number_i),
    .file_number_i  (file_number_i),
    .slot_i         (slot_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .out_slot_o     (out_slot_o),
    .out_block_o    (out_block_o),
    .out_file_o     (out_file_o),
    .last_o         (last_o),
    .usage_limit_i  (usage_limit_q),
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_wdata_o    (ram_wdata),
    .ram_raddr_o    (ram_raddr),
    .ram_rdata_i    (ram_rdata)
  );

endmodule

[src/bpcs_ram.sv]
module bpcs_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/bpcs_ctrl.sv]
module bpcs_ctrl
  import bpcs_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               kind_i,
  input  logic [31:0]              block_number_i,
  input  logic [15:0]              file_number_i,
  input  logic [3:0]               slot_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [2:0]               status_o,
  output logic [3:0]               out_slot_o,
  output logic [31:0]              out_block_o,
  output logic [15:0]              out_file_o,
  output logic                     last_o,
  input  logic [3:0]               usage_limit_i,
  output logic                     ram_we_o,
  output logic [$clog2(SLOTS)-1:0] ram_waddr_o,
  output entry_t                   ram_wdata_o,
  output logic [$clog2(SLOTS)-1:0] ram_raddr_o,
  input  entry_t                   ram_rdata_i
);

  `include "assert_macros.svh"

  localparam int SW = $clog2(SLOTS);
  localparam int RW = $clog2(SLOTS + 1);
  localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_LK_RD, S_LK_CK, S_SW_RD, S_SW_CK, S_OP_RD, S_OP_CK
  } state_e;

  state_e          state_q;
  logic [SLOTS-1:0] valid_q;
  logic [SW-1:0]   addr_q, hand_q;
  logic [RW-1:0]   run_q;
  kind_e           kind_q;
  logic [31:0]     blk_q;
  logic [15:0]     fil_q;
  logic [3:0]      slot_q;
  logic            rng_q;
  logic            out_valid_q, last_q;
  status_e         status_q;
  logic [3:0]      out_slot_q;
  logic [31:0]     out_block_q;
  logic [15:0]     out_file_q;

  entry_t          e;
  logic            vld, out_free, hit, victim, pinned, wb, rel_ok, emit;
  logic [SW-1:0]   next_addr;

  assign e         = ram_rdata_i;
  assign vld       = valid_q[addr_q];
  assign out_free  = !out_valid_q || !out_stall_i;
  assign hit       = vld && (e.blk == blk_q) && (e.fil == fil_q);
  assign pinned    = vld && (e.pin != 8'd0);
  assign wb        = vld && !pinned && e.dirty;
  assign victim    = !vld || (!pinned && !e.dirty && (e.usage == 4'd0));
  assign rel_ok    = rng_q && vld && (e.pin != 8'd0);
  assign next_addr = (addr_q == LAST_SLOT) ? '0 : addr_q + SW'(1);

  // a result item is loaded into the output register this cycle
  assign emit = out_free && (
      ((state_q == S_LK_CK) && hit) ||
      ((state_q == S_SW_CK) &&
       (victim || wb || (pinned && (run_q + RW'(1) == RW'(SLOTS))))) ||
      ((state_q == S_OP_CK) && (kind_q == KIND_RELEASE)));

  assign ram_raddr_o = addr_q;
  assign ram_waddr_o = addr_q;

  always_comb begin
    ram_we_o    = 1'b0;
    ram_wdata_o = e;
    unique case (state_q)
      S_LK_CK: begin
        if (hit && out_free) begin
          ram_we_o = 1'b1;
          if (e.pin != PIN_MAX) ram_wdata_o.pin = e.pin + 8'd1;
          if (e.usage < usage_limit_i) ram_wdata_o.usage = e.usage + 4'd1;
        end
      end
      S_SW_CK: begin
        if (victim) begin
          ram_we_o          = out_free;
          ram_wdata_o.blk   = blk_q;
          ram_wdata_o.fil   = fil_q;
          ram_wdata_o.pin   = 8'd1;
          ram_wdata_o.usage = {3'd0, usage_limit_i != 4'd0};
          ram_wdata_o.dirty = 1'b0;
        end else if (wb) begin
          ram_we_o          = out_free;
          ram_wdata_o.dirty = 1'b0;
        end else if (!pinned) begin
          ram_we_o          = 1'b1;
          ram_wdata_o.usage = e.usage - 4'd1;
        end
      end
      S_OP_CK: begin
        if (kind_q == KIND_RELEASE) begin
          ram_we_o        = rel_ok && out_free;
          ram_wdata_o.pin = e.pin - 8'd1;
        end else begin
          ram_we_o          = rng_q && vld;
          ram_wdata_o.dirty = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      addr_q      <= '0;
      hand_q      <= '0;
      run_q       <= '0;
      out_valid_q <= 1'b0;
      kind_q      <= KIND_NONE;
      status_q    <= ST_HIT;
    end else begin
      out_valid_q <= emit || (out_valid_q && out_stall_i);
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            kind_q <= kind_e'(kind_i);
            blk_q  <= block_number_i;
            fil_q  <= file_number_i;
            slot_q <= slot_i;
            rng_q  <= (32'(slot_i) < SLOTS);
            unique case (kind_e'(kind_i))
              KIND_READ: begin
                addr_q  <= '0;
                state_q <= S_LK_RD;
              end
              KIND_RELEASE, KIND_DIRTY: begin
                addr_q  <= SW'(slot_i);
                state_q <= S_OP_RD;
              end
              default: ;
            endcase
          end
        end
        S_LK_RD: state_q <= S_LK_CK;
        S_LK_CK: begin
          if (hit) begin
            if (out_free) begin
              status_q    <= ST_HIT;
              out_slot_q  <= 4'(addr_q);
              out_block_q <= blk_q;
              out_file_q  <= fil_q;
              last_q      <= 1'b1;
              state_q     <= S_IDLE;
            end
          end else if (addr_q == LAST_SLOT) begin
            addr_q  <= hand_q;
            run_q   <= '0;
            state_q <= S_SW_RD;
          end else begin
            addr_q  <= next_addr;
            state_q <= S_LK_RD;
          end
        end
        S_SW_RD: state_q <= S_SW_CK;
        S_SW_CK: begin
          if (victim) begin
            if (out_free) begin
              valid_q[addr_q] <= 1'b1;
              hand_q      <= next_addr;
              status_q    <= ST_MISS;
              out_slot_q  <= 4'(addr_q);
              out_block_q <= blk_q;
              out_file_q  <= fil_q;
              last_q      <= 1'b1;
              state_q     <= S_IDLE;
            end
          end else if (pinned) begin
            if (run_q + RW'(1) == RW'(SLOTS)) begin
              if (out_free) begin
                status_q    <= ST_NO_VICTIM;
                out_slot_q  <= 4'(addr_q);
                out_block_q <= blk_q;
                out_file_q  <= fil_q;
                last_q      <= 1'b1;
                state_q     <= S_IDLE;
              end
            end else begin
              run_q   <= run_q + RW'(1);
              hand_q  <= next_addr;
              addr_q  <= next_addr;
              state_q <= S_SW_RD;
            end
          end else if (wb) begin
            if (out_free) begin
              status_q    <= ST_WRITEBACK;
              out_slot_q  <= 4'(addr_q);
              out_block_q <= e.blk;
              out_file_q  <= e.fil;
              last_q      <= 1'b0;
              run_q       <= '0;
              hand_q      <= next_addr;
              addr_q      <= next_addr;
              state_q     <= S_SW_RD;
            end
          end else begin
            run_q   <= '0;
            hand_q  <= next_addr;
            addr_q  <= next_addr;
            state_q <= S_SW_RD;
          end
        end
        S_OP_RD: state_q <= S_OP_CK;
        S_OP_CK: begin
          if (kind_q == KIND_RELEASE) begin
            if (out_free) begin
              status_q    <= rel_ok ? ST_RELEASED : ST_BAD_REL;
              out_slot_q  <= slot_q;
              out_block_q <= rel_ok ? e.blk : 32'd0;
              out_file_q  <= rel_ok ? e.fil : 16'd0;
              last_q      <= 1'b1;
              state_q     <= S_IDLE;
            end
          end else begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign out_slot_o  = out_slot_q;
  assign out_block_o = out_block_q;
  assign out_file_o  = out_file_q;
  assign last_o      = last_q;

  // the pinned run never reaches a full pass without ending the sweep
  `AST_CLK(a_run_bound, run_q < RW'(SLOTS))
  // during a sweep the read address follows the hand
  `AST_CLK(a_hand_track, (state_q == S_SW_CK) |-> (addr_q == hand_q))
  // only writebacks leave the item open
  `AST_CLK(a_wb_not_last, (out_valid_q && status_q == ST_WRITEBACK) |-> !last_q)
  // no ram write while idle
  `AST_NEVER(a_idle_write, state_q == S_IDLE && ram_we_o)

endmodule

[verif/tb.sv]
module tb;
  import bpcs_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  kind_i = KIND_NONE;
  logic [31:0] block_number_i = '0;
  logic [15:0] file_number_i = '0;
  logic [3:0]  slot_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  status_o;
  logic [3:0]  out_slot_o;
  logic [31:0] out_block_o;
  logic [15:0] out_file_o;
  logic        last_o;
  logic        cfg_we_i = 1'b0;
  logic [3:0]  cfg_data_i = '0;

  localparam int NSLOT = 16;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  slot;
    logic [31:0] blk;
    logic [15:0] fil;
    logic        last;
  } pool_result_t;

  class pool_scoreboard;
    logic        valid [NSLOT];
    logic [31:0] blk [NSLOT];
    logic [15:0] fil [NSLOT];
    logic [7:0]  pin [NSLOT];
    logic [3:0]  usage [NSLOT];
    logic        dirty [NSLOT];
    logic [3:0]  hand;
    logic [3:0]  usage_limit;
    pool_result_t pending [$];
    int errors;

    function void clear();
      for (int i = 0; i < NSLOT; i++) begin
        valid[i] = 1'b0; blk[i] = '0; fil[i] = '0; pin[i] = '0; usage[i] = '0;
        dirty[i] = 1'b0;
      end
      hand = '0;
      usage_limit = 4'd5;
      errors = 0;
    endfunction

    function void push(status_e st, logic [3:0] s, logic [31:0] b, logic [15:0] f,
                       logic l);
      pool_result_t r;
      r.status = st; r.slot = s; r.blk = b; r.fil = f; r.last = l;
      pending.push_back(r);
    endfunction

    function void note_item(kind_e k, logic [31:0] b, logic [15:0] f, logic [3:0] s);
      int pinned_run;
      int wbs;
      if (k == KIND_READ) begin
        for (int i = 0; i < NSLOT; i++)
          if (valid[i] && blk[i] == b && fil[i] == f) begin
            if (pin[i] < PIN_MAX) pin[i]++;
            if (usage[i] < usage_limit) usage[i]++;
            push(ST_HIT, 4'(i), b, f, 1'b1);
            return;
          end
        pinned_run = 0;
        wbs = 0;
        for (int g = 0; g < NSLOT * 40; g++) begin
          if (!valid[hand]) break;
          if (pin[hand] != 0) begin
            pinned_run++;
            if (pinned_run >= NSLOT) begin
              push(ST_NO_VICTIM, hand, b, f, 1'b1);
              return;
            end
          end else begin
            pinned_run = 0;
            if (dirty[hand]) begin
              if (wbs < NSLOT) begin
                push(ST_WRITEBACK, hand, blk[hand], fil[hand], 1'b0);
                wbs++;
              end
              dirty[hand] = 1'b0;
            end else if (usage[hand] == 0) begin
              break;
            end else begin
              usage[hand]--;
            end
          end
          hand = hand + 4'd1;
        end
        valid[hand] = 1'b1; blk[hand] = b; fil[hand] = f; pin[hand] = 8'd1;
        usage[hand] = (usage_limit >= 1) ? 4'd1 : 4'd0;
        dirty[hand] = 1'b0;
        push(ST_MISS, hand, b, f, 1'b1);
        hand = hand + 4'd1;
      end else if (k == KIND_RELEASE) begin
        if (!valid[s] || pin[s] == 0) begin
          push(ST_BAD_REL, s, '0, '0, 1'b1);
        end else begin
          pin[s]--;
          push(ST_RELEASED, s, blk[s], fil[s], 1'b1);
        end
      end else if (k == KIND_DIRTY) begin
        if (valid[s]) dirty[s] = 1'b1;
      end
    endfunction

    function void check_result(pool_result_t got);
      pool_result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $realtime, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $realtime, want.status, got.status);
        errors++;
      end
      if (got.slot !== want.slot) begin
        $display("%0t: slot expected %0d actual %0d", $realtime, want.slot, got.slot);
        errors++;
      end
      if (got.blk !== want.blk) begin
        $display("%0t: block expected %h actual %h", $realtime, want.blk, got.blk);
        errors++;
      end
      if (got.fil !== want.fil) begin
        $display("%0t: file expected %h actual %h", $realtime, want.fil, got.fil);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last expected %0d actual %0d", $realtime, want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  pool_scoreboard pool;
  bit quiet;

  buffer_pool_clock_sweep i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .kind_i, .block_number_i,
    .file_number_i, .slot_i, .out_valid_o, .out_stall_i, .status_o, .out_slot_o,
    .out_block_o, .out_file_o, .last_o, .cfg_we_i, .cfg_data_i
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // random stall bursts on the result side
  initial begin
    int n;
    forever begin
      @(posedge clk_i);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 9);
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      pool.check_result({status_o, out_slot_o, out_block_o, out_file_o, last_o});
  end

  // small tag space so that hits and repeats happen often
  logic [31:0] tag_blk [8];
  logic [15:0] tag_fil [8];

  task automatic send_item(kind_e k, logic [31:0] b, logic [15:0] f, logic [3:0] s);
    int n;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 9);
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= k;
    block_number_i <= b;
    file_number_i <= f;
    slot_i <= s;
    do @(posedge clk_i); while (in_stall_o);
    pool.note_item(k, b, f, s);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pool.pending.size() != 0) @(posedge clk_i);
    // mark dirty gives no result and may still be in flight
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [3:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    pool.usage_limit = v;
  endtask

  task automatic random_item();
    int r;
    int t;
    r = $urandom_range(0, 99);
    t = $urandom_range(0, 7);
    if (r < 50)
      send_item(KIND_READ, tag_blk[t], tag_fil[t], 4'($urandom));
    else if (r < 75)
      send_item(KIND_RELEASE, $urandom, 16'($urandom), 4'($urandom));
    else if (r < 93)
      send_item(KIND_DIRTY, $urandom, 16'($urandom), 4'($urandom));
    else if (r < 97)
      send_item(KIND_READ, $urandom, 16'($urandom), 4'($urandom));
    else
      send_item(KIND_NONE, $urandom, 16'($urandom), 4'($urandom));
  endtask

  initial begin
    pool = new();
    pool.clear();
    quiet = 0;
    for (int i = 0; i < 8; i++) begin
      tag_blk[i] = $urandom;
      tag_fil[i] = 16'($urandom);
    end
    tag_blk[0] = '1; tag_fil[0] = '1;
    tag_blk[1] = '0; tag_fil[1] = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: good and bad releases, misses, hits, extremes of the tag fields
    send_item(KIND_RELEASE, '0, '0, 4'd15);
    send_item(KIND_DIRTY, '0, '0, 4'd3);
    send_item(KIND_READ, 32'hFFFF_FFFF, 16'hFFFF, 4'd0);
    send_item(KIND_READ, 32'h0, 16'h0, 4'd15);
    send_item(KIND_READ, 32'hFFFF_FFFF, 16'hFFFF, 4'd0);
    send_item(KIND_RELEASE, '0, '0, 4'd0);
    send_item(KIND_RELEASE, '0, '0, 4'd0);
    send_item(KIND_RELEASE, '0, '0, 4'd0);
    send_item(KIND_DIRTY, '0, '0, 4'd0);
    send_item(KIND_NONE, 32'hA5A5_A5A5, 16'h5A5A, 4'd5);
    // fill every slot pinned, then one more read finds no victim
    for (int i = 2; i < 17; i++)
      send_item(KIND_READ, 32'h1000 + i, 16'(i), 4'd0);
    send_item(KIND_READ, 32'h5555_AAAA, 16'hAAAA, 4'd0);
    // unpin all and dirty all so the sweep emits writebacks
    for (int i = 0; i < 16; i++) begin
      send_item(KIND_RELEASE, '0, '0, 4'(i));
      send_item(KIND_DIRTY, '0, '0, 4'(i));
    end
    send_item(KIND_READ, 32'h0BAD_0BAD, 16'h1234, 4'd0);

    write_limit(4'd15);
    repeat (70) random_item();
    write_limit(4'd0);
    repeat (50) random_item();
    write_limit(4'd1);
    repeat (50) random_item();
    write_limit(4'd7);
    quiet = 1;
    repeat (50) random_item();
    drain();
    if (pool.errors == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

  initial begin
    #30000000;
    $display("tb failed");
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/bpcs_pkg.sv
src/bpcs_ram.sv
src/bpcs_ctrl.sv
src/buffer_pool_clock_sweep.sv
verif/tb.sv
